### src/assert_macros.svh
// assertion macros shared by the decimal writer modules
// depends on clk and rst_n being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### src/ldnw_pkg.sv
// shared types, constants and helpers of the decimal number writer
// no dependencies
`timescale 1ns / 1ps

package ldnw_pkg;

    localparam int MAX_DIGITS_DEF = 10;
    localparam int MAX_DIGITS_HI  = 20;

    localparam int NUMBER_W   = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int DIX_W      = $clog2(BCD_DIGITS);
    localparam int CONV_BITS  = 4;
    localparam int CONV_STEPS = NUMBER_W / CONV_BITS;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    // counts and exponents sized for the full parameter range
    localparam int CNT_W = $clog2(MAX_DIGITS_HI + 1);
    localparam int EXP_W = $clog2(15 + MAX_DIGITS_HI + 1);

    localparam int IN_FIELDS_W = 52;
    localparam int IN_W        = 56;
    localparam int OUT_W       = 8;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_POINT = 8'h2E;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    typedef logic [BCD_W-1:0] bcd_t;

    typedef struct packed {
        logic [7:0]       cursor;
        bcd_t             bcd;
        logic [CNT_W-1:0] int_cnt;
        logic [CNT_W-1:0] frac_cnt;
        logic [3:0]       shift;
        logic             keep;
    } desc_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_CONV,
        FS_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BS_CMD,
        BS_INT,
        BS_DOT,
        BS_FRAC
    } back_state_t;

    // one double-dabble step: adjust every digit, shift in one binary bit
    function automatic bcd_t dabble_step(input bcd_t d, input logic b);
        bcd_t a;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            a[i*4 +: 4] = (d[i*4 +: 4] >= 4'd5) ? d[i*4 +: 4] + 4'd3 : d[i*4 +: 4];
        end
        return {a[BCD_W-2:0], b};
    endfunction

endpackage

### src/ldnw_front.sv
// front end: accepts a request, clamps the counts, converts to bcd
// depends on ldnw_pkg
`timescale 1ns / 1ps

module ldnw_front #(
    parameter int MAX_DIGITS = ldnw_pkg::MAX_DIGITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [ldnw_pkg::IN_W-1:0] s_tdata,
    output logic                    push,
    output ldnw_pkg::desc_t         push_desc,
    input  logic                    q_full
);
    import ldnw_pkg::*;

    front_state_t state_reg, state_next;

    logic [NUMBER_W-1:0] bin_reg, bin_next;
    bcd_t                bcd_conv;
    logic [STEP_W-1:0]   step_reg, step_next;
    desc_t               desc_reg, desc_next;

    logic [1:0]       f_row;
    logic [4:0]       f_column;
    logic [3:0]       f_idig, f_fdig, f_shift;
    logic             f_keep;
    logic [CNT_W-1:0] icnt, fmin, fcnt;
    logic [CNT_W:0]   isum;
    logic             accept;

    assign f_row    = s_tdata[1:0];
    assign f_column = s_tdata[6:2];
    assign f_idig   = s_tdata[42:39];
    assign f_keep   = s_tdata[43];
    assign f_fdig   = s_tdata[47:44];
    assign f_shift  = s_tdata[51:48];

    // count clamping
    always_comb
    begin
        icnt = (f_idig > MAX_DIGITS) ? CNT_W'(MAX_DIGITS) : CNT_W'(f_idig);
        fmin = (f_fdig > f_shift) ? CNT_W'(f_shift) : CNT_W'(f_fdig);
        isum = (CNT_W+1)'(icnt) + (CNT_W+1)'(fmin);
        fcnt = (isum > MAX_DIGITS) ? CNT_W'(MAX_DIGITS) - icnt : fmin;
    end

    // four dabble steps per cycle
    always_comb
    begin
        bcd_conv = desc_reg.bcd;
        for (int j = 0; j < CONV_BITS; j++)
        begin
            bcd_conv = dabble_step(bcd_conv, bin_reg[NUMBER_W-1-j]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE: if (s_tvalid) state_next = FS_CONV;
            FS_CONV: if (step_reg == STEP_W'(CONV_STEPS - 1)) state_next = FS_PUSH;
            FS_PUSH: if (!q_full) state_next = FS_IDLE;
            default: state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        push     = 1'b0;
        unique case (state_reg)
            FS_IDLE: s_tready = 1'b1;
            FS_CONV: ;
            FS_PUSH: push = !q_full;
            default: ;
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign push_desc = desc_reg;

    always_comb
    begin
        bin_next  = bin_reg;
        step_next = step_reg;
        desc_next = desc_reg;
        if (accept)
        begin
            bin_next           = s_tdata[38:7];
            step_next          = '0;
            desc_next.cursor   = {1'b1, f_row, f_column};
            desc_next.bcd      = '0;
            desc_next.int_cnt  = icnt;
            desc_next.frac_cnt = fcnt;
            desc_next.shift    = f_shift;
            desc_next.keep     = f_keep;
        end
        else if (state_reg == FS_CONV)
        begin
            bin_next      = bin_reg << CONV_BITS;
            step_next     = step_reg + 1'b1;
            desc_next.bcd = bcd_conv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        desc_reg <= desc_next;
    end

endmodule

### src/ldnw_queue.sv
// two-entry queue of decoded requests between front and back
// depends on ldnw_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ldnw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ldnw_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ldnw_pkg::desc_t head_desc
);
    import ldnw_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_desc  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_desc;
        end
    end

    `ASSERT_NEVER(a_push_when_full, push && full, "request pushed into full queue")
    `ASSERT_NEVER(a_pop_when_empty, pop && !head_valid, "pop from empty queue")

endmodule

### src/ldnw_back.sv
// back end: walks one queued request and sends its bytes one per cycle while the output is not stalled
// depends on ldnw_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ldnw_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  ldnw_pkg::desc_t head_desc,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // byte_out
    output logic            m_tlast,   // last
    output logic            m_tuser    // is_data
);
    import ldnw_pkg::*;

    back_state_t      phase_reg, phase_next;
    logic [CNT_W-1:0] int_left_reg, frac_left_reg;
    logic [EXP_W-1:0] exp_reg, exp_m1;
    logic             blank_reg;

    logic             out_valid_reg, out_last_reg, out_user_reg;
    logic [7:0]       out_byte_reg;

    logic             load;
    logic [7:0]       byte_c, digit_ch;
    logic             last_c, user_c, use_space;
    logic             in_range;
    logic [DIX_W-1:0] dig_idx;
    logic [3:0]       digit;

    assign load = head_valid && (!out_valid_reg || m_tready);

    // digit of weight 10^(exp_reg-1); beyond the bcd word it reads as zero
    always_comb
    begin
        exp_m1   = exp_reg - 1'b1;
        in_range = (exp_reg != '0) && (exp_m1 < EXP_W'(BCD_DIGITS));
        dig_idx  = exp_m1[DIX_W-1:0];
        digit    = in_range ? head_desc.bcd[dig_idx*4 +: 4] : 4'd0;
        digit_ch = ASCII_ZERO | {4'd0, digit};
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (load)
        begin
            unique case (phase_reg)
                BS_CMD:
                    if (head_desc.int_cnt != '0)       phase_next = BS_INT;
                    else if (head_desc.frac_cnt != '0) phase_next = BS_DOT;
                BS_INT:
                    if (int_left_reg == CNT_W'(1))
                        phase_next = (head_desc.frac_cnt != '0) ? BS_DOT : BS_CMD;
                BS_DOT:  phase_next = BS_FRAC;
                BS_FRAC: if (frac_left_reg == CNT_W'(1)) phase_next = BS_CMD;
                default: phase_next = BS_CMD;
            endcase
        end
    end

    always_comb
    begin
        byte_c    = digit_ch;
        user_c    = KIND_CHAR;
        last_c    = 1'b0;
        use_space = 1'b0;
        unique case (phase_reg)
            BS_CMD:
            begin
                byte_c = head_desc.cursor;
                user_c = KIND_CMD;
                last_c = (head_desc.int_cnt == '0) && (head_desc.frac_cnt == '0);
            end
            BS_INT:
            begin
                use_space = blank_reg && (digit == 4'd0) && (int_left_reg > CNT_W'(1));
                byte_c    = use_space ? ASCII_SPACE : digit_ch;
                last_c    = (int_left_reg == CNT_W'(1)) && (head_desc.frac_cnt == '0);
            end
            BS_DOT:  byte_c = ASCII_POINT;
            BS_FRAC: last_c = (frac_left_reg == CNT_W'(1));
            default: ;
        endcase
    end

    assign pop = load && last_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= BS_CMD;
            int_left_reg  <= '0;
            frac_left_reg <= '0;
            exp_reg       <= '0;
            blank_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
                case (phase_reg)
                    BS_CMD:
                    begin
                        int_left_reg  <= head_desc.int_cnt;
                        frac_left_reg <= head_desc.frac_cnt;
                        exp_reg       <= EXP_W'(head_desc.shift) + EXP_W'(head_desc.int_cnt);
                        blank_reg     <= !head_desc.keep;
                    end
                    BS_INT:
                    begin
                        int_left_reg <= int_left_reg - 1'b1;
                        exp_reg      <= exp_m1;
                        blank_reg    <= use_space;
                    end
                    BS_FRAC:
                    begin
                        frac_left_reg <= frac_left_reg - 1'b1;
                        exp_reg       <= exp_m1;
                    end
                    default: ;
                endcase
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= byte_c;
            out_user_reg <= user_c;
            out_last_reg <= last_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    `ASSERT_CLK(a_walk_has_head, (phase_reg != BS_CMD) |-> head_valid, "walk without request")
    `ASSERT_CLK(a_frac_count, (phase_reg == BS_FRAC) |-> (frac_left_reg != '0), "frac underrun")

endmodule

### src/lcd_decimal_number_writer.sv
// top level of the decimal number writer for a character display
// depends on ldnw_pkg, ldnw_front, ldnw_queue and ldnw_back
`timescale 1ns / 1ps

// Turns one request (row, column, 32-bit unsigned number, digit counts,
// point shift, zero-keep flag) into the byte run a character display needs:
// a cursor address command 0x80 | (row*0x20 + column), then ASCII digits of
// the integer part, then '.' and the fraction digits when any remain after
// clamping. Leading integer zeros become spaces unless keep_zeros is set;
// the last integer digit always prints. Digits of weight 10^10 and up read
// as '0'. Output bytes carry tuser = 0 for the command and 1 for characters,
// and tlast marks the final byte of each run (the command itself when no
// characters follow). The front end takes a request when idle and runs a
// double-dabble converter at four bits per cycle, and takes no new request
// until the converted one is pushed into the queue. The back end sends
// 1 + I (+ 1 + F when F > 0) bytes at one per cycle while the output is not
// stalled, up to 12 with the default digit limit. A two-entry queue sits
// between the halves, so the converter works on the next request while the
// back end is still sending, and a registered output stage holds its byte
// while the output is stalled; no new byte is loaded until it is taken.
module lcd_decimal_number_writer #(
    parameter int MAX_DIGITS = ldnw_pkg::MAX_DIGITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // request channel
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // row[1:0], column[6:2], number[38:7], int_digits[42:39],
    // keep_zeros[43], frac_digits[47:44], point_shift[51:48], zero pad above
    input  logic [ldnw_pkg::IN_W-1:0] s_tdata,
    // byte channel
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,  // byte_out[7:0]
    output logic                      m_tlast,  // last
    output logic                      m_tuser   // is_data
);
    import ldnw_pkg::*;

    // decoded request handed from front to queue
    logic  push, q_full;
    desc_t push_desc;

    // queue head seen by the back end
    logic  head_valid, pop;
    desc_t head_desc;

    ldnw_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_desc (push_desc),
        .q_full    (q_full)
    );

    ldnw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    // back end walks command, integer digits, point, fraction digits
    ldnw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

### bench/lcd_decimal_number_writer_test.sv
`timescale 1ns / 1ps

// self-checking bench for lcd_decimal_number_writer: random and directed display requests,
// an own prediction of every cursor and character byte, field-by-field compare on the byte stream
// depends on ldnw_pkg and lcd_decimal_number_writer
module lcd_decimal_number_writer_test;
    import ldnw_pkg::*;

    localparam int DIGIT_LIMIT = MAX_DIGITS_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;

    // one request waiting to be offered, with the idle cycles that go before it
    typedef struct {
        logic [IN_W-1:0] data;
        int              gap;
        bit              settle;   // hold the request back until no byte is outstanding
    } request_t;

    // one byte on the display channel
    typedef struct {
        logic       kind;
        logic [7:0] code;
        logic       last;
    } lcd_byte_t;

    logic            clk      = 1'b0;
    logic            rst_n    = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [7:0]      m_tdata;
    logic            m_tlast;
    logic            m_tuser;

    request_t  pending[$];       // requests not yet offered
    lcd_byte_t bytes_due[$];     // display bytes predicted but not yet seen
    request_t  next_req;

    logic req_fire = 1'b0;       // request taken at the last rising edge
    logic out_fire = 1'b0;       // byte taken at the last rising edge
    logic tx_offer = 1'b0;
    int   tx_gap    = 0;
    int   rx_wait   = 0;
    bit   rx_calm   = 1'b0;
    int   hold_req  = 0;         // bumped by the sequencer to ask for a long output stall
    int   hold_seen = 0;
    int   fail_cnt  = 0;

    lcd_decimal_number_writer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // ascii digit of weight 10^e; a 32-bit value has nothing at 10^10 and up
    function automatic logic [7:0] decimal_char(input logic [31:0] value, input int e);
        longint unsigned p;
        p = 1;
        if (e >= 10)
            return ASCII_ZERO;
        repeat (e) p = p * 10;
        return 8'((longint'(value) / p) % 10) + ASCII_ZERO;
    endfunction

    // expected byte run of one accepted request, appended to bytes_due
    function automatic void predict_byte_run(input logic [IN_W-1:0] d);
        logic [1:0]  row;
        logic [4:0]  col;
        logic [31:0] value;
        int          icnt;
        int          fcnt;
        int          shift;
        bit          blanking;
        logic [7:0]  c;
        lcd_byte_t   run[$];
        row   = d[1:0];
        col   = d[6:2];
        value = d[38:7];
        icnt  = d[42:39];
        fcnt  = d[47:44];
        shift = d[51:48];
        // clamp integer count, then fraction count to shift and to what is left
        if (icnt > DIGIT_LIMIT)
            icnt = DIGIT_LIMIT;
        if (fcnt > shift)
            fcnt = shift;
        if (icnt + fcnt > DIGIT_LIMIT)
            fcnt = DIGIT_LIMIT - icnt;
        // cursor address command leads every run
        run.push_back(lcd_byte_t'{KIND_CMD, ((8'(row) * 8'h20 + 8'(col)) | 8'h80), 1'b0});
        blanking = !d[43];
        for (int k = 0; k < icnt; k++)
        begin
            c = decimal_char(value, shift + icnt - 1 - k);
            // leading zeros turn to spaces, never the last integer digit
            if (blanking && c == ASCII_ZERO && k + 1 < icnt)
                c = ASCII_SPACE;
            else
                blanking = 1'b0;
            run.push_back(lcd_byte_t'{KIND_CHAR, c, 1'b0});
        end
        if (fcnt > 0)
        begin
            run.push_back(lcd_byte_t'{KIND_CHAR, ASCII_POINT, 1'b0});
            for (int k = 0; k < fcnt; k++)
                run.push_back(lcd_byte_t'{KIND_CHAR, decimal_char(value, shift - 1 - k), 1'b0});
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            bytes_due.push_back(run[i]);
    endfunction

    task automatic queue_request(input logic [1:0] row, input logic [4:0] col,
                                 input logic [31:0] value, input logic [3:0] idig,
                                 input logic keep, input logic [3:0] fdig,
                                 input logic [3:0] shift, input int gap, input bit settle);
        request_t r;
        r.data   = {4'b0000, shift, fdig, keep, idig, value, col, row};
        r.gap    = gap;
        r.settle = settle;
        pending.push_back(r);
    endtask

    // counts mostly in the legal range, now and then above it to hit the clamps
    function automatic logic [3:0] random_count();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(11, 15));
        return 4'($urandom_range(0, 10));
    endfunction

    task automatic queue_random_request(input int gap_max, input bit settle);
        logic [31:0] value;
        case ($urandom_range(0, 3))
            0: value = $urandom();
            1: value = $urandom_range(0, 999);
            2: value = $urandom_range(0, 99999999);
            default: value = $urandom() >> $urandom_range(0, 31);
        endcase
        queue_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), value,
                      random_count(), 1'($urandom_range(0, 1)), random_count(),
                      random_count(), $urandom_range(0, gap_max), settle);
    endtask

    // block the sequencer until every request is in and every byte is out
    task automatic wait_drained();
        while (pending.size() != 0 || tx_offer || s_tvalid || bytes_due.size() != 0)
            @(negedge clk);
    endtask

    // request driver: one request at a time, gaps drawn per request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            tx_offer = s_tvalid && !req_fire;
            if (req_fire)
                tx_gap = (pending.size() > 0) ? pending[0].gap : 0;
            if (!tx_offer)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending.size() > 0 && !(pending[0].settle && bytes_due.size() != 0))
                begin
                    next_req = pending.pop_front();
                    s_tdata  <= next_req.data;
                    tx_offer = 1'b1;
                end
            end
            s_tvalid <= tx_offer;
        end
    end

    // byte receiver: stall per byte, calm stretches, and the long hold on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                rx_wait   = HOLD_CYCLES;
            end
            else if (out_fire)
            begin
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // predict on each accepted request, check each accepted byte against the oldest one due
    always @(posedge clk)
    begin
        lcd_byte_t want;
        req_fire <= rst_n && s_tvalid && s_tready;
        out_fire <= rst_n && m_tvalid && m_tready;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_byte_run(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (bytes_due.size() == 0)
                begin
                    $error("unexpected byte: is_data %b byte_out %h last %b",
                           m_tuser, m_tdata, m_tlast);
                    fail_cnt++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("is_data: expected %b, got %b", want.kind, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata !== want.code)
                    begin
                        $error("byte_out: expected %h, got %h", want.code, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, m_tlast);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // sequencer: directed corners, a stalled-output burst, then random segments
    initial
    begin
        bit calm;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // cursor command alone, with the highest address too
        queue_request(2'd0, 5'd0, 32'd0, 4'd0, 1'b0, 4'd0, 4'd0, 0, 1'b0);
        queue_request(2'd3, 5'd31, 32'd5, 4'd0, 1'b1, 4'd0, 4'd0, 3, 1'b0);
        // full width, all ones, zeros kept and blanked
        queue_request(2'd3, 5'd31, 32'hFFFFFFFF, 4'd10, 1'b1, 4'd0, 4'd0, 0, 1'b0);
        queue_request(2'd0, 5'd0, 32'd0, 4'd10, 1'b0, 4'd0, 4'd0, 2, 1'b0);
        queue_request(2'd1, 5'd21, 32'd0, 4'd10, 1'b1, 4'd0, 4'd0, 0, 1'b0);
        // single integer digit of zero still prints
        queue_request(2'd2, 5'd10, 32'd0, 4'd1, 1'b0, 4'd0, 4'd0, 1, 1'b0);
        queue_request(2'd2, 5'd3, 32'd7, 4'd1, 1'b0, 4'd0, 4'd0, 0, 1'b0);
        // no integer digits: the point follows the cursor command
        queue_request(2'd1, 5'd4, 32'd12345, 4'd0, 1'b0, 4'd5, 4'd5, 0, 1'b0);
        // integer count above the limit clamps
        queue_request(2'd0, 5'd8, 32'd1234567890, 4'd15, 1'b0, 4'd0, 4'd0, 4, 1'b0);
        // leading zeros with and without padding
        queue_request(2'd1, 5'd0, 32'd42, 4'd6, 1'b0, 4'd2, 4'd2, 0, 1'b0);
        queue_request(2'd1, 5'd0, 32'd42, 4'd6, 1'b1, 4'd2, 4'd2, 0, 1'b0);
        // top decimal digit of a 32-bit value
        queue_request(2'd2, 5'd17, 32'd1000000000, 4'd10, 1'b0, 4'd0, 4'd0, 0, 1'b0);
        // fraction clamped to shift, then to what the total leaves
        queue_request(2'd3, 5'd1, 32'd987654321, 4'd4, 1'b0, 4'd8, 4'd6, 0, 1'b0);
        queue_request(2'd0, 5'd2, 32'd987654321, 4'd7, 1'b0, 4'd5, 4'd5, 5, 1'b0);
        queue_request(2'd0, 5'd9, 32'd3141592653, 4'd10, 1'b0, 4'd10, 4'd10, 0, 1'b0);
        queue_request(2'd3, 5'd30, 32'hFFFFFFFF, 4'd3, 1'b0, 4'd15, 4'd15, 0, 1'b0);
        // shifts past the last real digit: weights of 10^10 and up read as zero
        queue_request(2'd1, 5'd12, 32'hFFFFFFFF, 4'd2, 1'b0, 4'd3, 4'd11, 0, 1'b0);
        queue_request(2'd2, 5'd12, 32'hFFFFFFFF, 4'd5, 1'b1, 4'd4, 4'd12, 2, 1'b0);
        queue_request(2'd3, 5'd12, 32'd4000000000, 4'd10, 1'b0, 4'd0, 4'd10, 0, 1'b0);
        queue_request(2'd0, 5'd5, 32'h80000000, 4'd15, 1'b1, 4'd15, 4'd13, 0, 1'b0);
        // alternating bit patterns
        queue_request(2'd2, 5'd21, 32'h55555555, 4'd10, 1'b0, 4'd14, 4'd14, 0, 1'b0);
        queue_request(2'd1, 5'd10, 32'hAAAAAAAA, 4'd5, 1'b0, 4'd5, 4'd5, 6, 1'b0);
        wait_drained();

        // output held for a long stretch while requests keep coming back to back
        hold_req++;
        repeat (30) queue_random_request(0, 1'b0);
        wait_drained();

        // random segments, each opening after all bytes are out, calm or gappy
        for (int seg = 0; seg < 9; seg++)
        begin
            calm = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < 40; i++)
                queue_random_request(calm ? 0 : 10, i == 0 || $urandom_range(0, 24) == 0);
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (bytes_due.size() != 0)
        begin
            $error("bytes: expected %0d more, got none", bytes_due.size());
            fail_cnt++;
        end

        if (fail_cnt == 0)
            $display("[lcd_decimal_number_writer] OK");
        else
            $display("[lcd_decimal_number_writer] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("[lcd_decimal_number_writer] ERROR");
        $finish;
    end

endmodule
